// ===== rtl/core/extent_sector_allocator_defines.svh =====
// Assertion macros shared by the extent sector allocator checkers.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef EXTENT_SECTOR_ALLOCATOR_DEFINES_SVH
`define EXTENT_SECTOR_ALLOCATOR_DEFINES_SVH

`define ESA_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("extent_sector_allocator: same-cycle check failed");

`define ESA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("extent_sector_allocator: next-cycle check failed");

`endif

// ===== rtl/core/esa_pkg.sv =====
// Shared types for the extent sector allocator.
// No dependencies; used by the top level, the arithmetic unit and the checker.
`default_nettype none

package esa_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef struct packed {
    logic short_fit;
    logic rem_done;
    logic addr_hit;
    logic owner_match;
  } alu_flags_t;

endpackage

`default_nettype wire

// ===== rtl/core/extent_sector_allocator.sv =====
// Top level of the first-fit extent sector allocator: sequencer and extent table.
// Depends on esa_pkg, esa_ram and esa_alu.
//
//   channel  direction  handshake               fields
//   in_      input      in_valid / in_ready     command, file_number, sector_count, sector_address
//   out_     output     out_valid / out_ready   owner_file, table_overflow
//
// A delete, a read or a nonzero write walks the extent table through one RAM read port.
// A write that may split a hole in a full table first walks it once to check the split.
// A split then moves each later entry up by one, then writes the split entry and the new hole.
// After reset the block writes the initial free extent before it is ready.
// A read result sits in an output register; a further read waits there only if it is not taken.
`default_nettype none

module extent_sector_allocator #(
  parameter int MAX_EXTENTS = 256,
  parameter int SECTOR_BITS = 30,
  parameter int FILE_BITS   = 16
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire esa_pkg::cmd_t             in_command,
  input  wire logic [FILE_BITS-1:0]      in_file_number,
  input  wire logic [SECTOR_BITS:0]      in_sector_count,
  input  wire logic [SECTOR_BITS-1:0]    in_sector_address,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [FILE_BITS:0]      out_owner_file,
  output logic                           out_table_overflow
);

  import esa_pkg::*;

  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int TW = $clog2(MAX_EXTENTS + 1);
  localparam int EW = 1 + FILE_BITS + SECTOR_BITS;

  typedef enum logic [8:0] {
    S_INIT  = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_RD    = 9'b000000100,
    S_EVAL  = 9'b000001000,
    S_SH_RD = 9'b000010000,
    S_SH_WR = 9'b000100000,
    S_SP_A  = 9'b001000000,
    S_SP_B  = 9'b010000000,
    S_RES   = 9'b100000000
  } state_t;

  state_t                 state_r, state_nxt;
  cmd_t                   cmd_r, cmd_nxt;
  logic [FILE_BITS-1:0]   file_r, file_nxt;
  logic [SECTOR_BITS:0]   count_r, count_nxt;
  logic [SECTOR_BITS-1:0] addr_r, addr_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic [SECTOR_BITS-1:0] first_r, first_nxt;
  logic [SECTOR_BITS:0]   rem_r, rem_nxt;
  logic                   check_r, check_nxt;
  logic [IW-1:0]          si_r, si_nxt;
  logic [IW-1:0]          j_r, j_nxt;
  logic [SECTOR_BITS-1:0] split_last_r, split_last_nxt;
  logic [SECTOR_BITS-1:0] old_last_r, old_last_nxt;
  logic [TW-1:0]          total_r, total_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [FILE_BITS:0]     res_owner_r, res_owner_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [FILE_BITS:0]     out_owner_r, out_owner_nxt;
  logic                   out_ovf_r, out_ovf_nxt;

  logic                   ram_we;
  logic [IW-1:0]          ram_waddr;
  logic [EW-1:0]          ram_wdata;
  logic                   ram_re;
  logic [IW-1:0]          ram_raddr;
  logic [EW-1:0]          ram_rdata;

  logic                   d_free;
  logic [FILE_BITS-1:0]   d_owner;
  logic [SECTOR_BITS-1:0] d_last;
  logic [SECTOR_BITS:0]   rem_after;
  logic [SECTOR_BITS-1:0] split_last;
  alu_flags_t             flags;
  logic                   at_end;
  logic [IW-1:0]          top_idx;
  logic                   adv;

  assign d_free  = ram_rdata[EW-1];
  assign d_owner = ram_rdata[EW-2 -: FILE_BITS];
  assign d_last  = ram_rdata[SECTOR_BITS-1:0];
  assign top_idx = IW'(total_r - TW'(1));
  assign at_end  = (TW'(idx_r) + TW'(1)) == total_r;

  esa_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_EXTENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  esa_alu #(
    .SECTOR_BITS (SECTOR_BITS),
    .FILE_BITS   (FILE_BITS)
  ) u_alu (
    .rem        (rem_r),
    .first      (first_r),
    .last       (d_last),
    .addr       (addr_r),
    .file       (file_r),
    .owner      (d_owner),
    .rem_after  (rem_after),
    .split_last (split_last),
    .flags      (flags)
  );

  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    file_nxt       = file_r;
    count_nxt      = count_r;
    addr_nxt       = addr_r;
    idx_nxt        = idx_r;
    first_nxt      = first_r;
    rem_nxt        = rem_r;
    check_nxt      = check_r;
    si_nxt         = si_r;
    j_nxt          = j_r;
    split_last_nxt = split_last_r;
    old_last_nxt   = old_last_r;
    total_nxt      = total_r;
    ovf_nxt        = ovf_r;
    res_owner_nxt  = res_owner_r;
    out_valid_nxt  = out_valid_r;
    out_owner_nxt  = out_owner_r;
    out_ovf_nxt    = out_ovf_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = '0;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;
    adv            = 1'b0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b1, {FILE_BITS{1'b0}}, {SECTOR_BITS{1'b1}}};
        total_nxt = TW'(1);
        state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd_nxt   = in_command;
          file_nxt  = in_file_number;
          count_nxt = in_sector_count;
          addr_nxt  = in_sector_address;
          idx_nxt   = '0;
          first_nxt = '0;
          rem_nxt   = in_sector_count;
          check_nxt = total_r >= TW'(MAX_EXTENTS);
          unique case (in_command)
            CMD_WRITE: begin
              if (in_sector_count != '0) begin
                state_nxt = S_RD;
              end
            end
            CMD_DELETE, CMD_READ: state_nxt = S_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        unique case (cmd_r)
          CMD_READ: begin
            if (flags.addr_hit || at_end) begin
              res_owner_nxt = (d_free || !flags.addr_hit) ? '1 : {1'b0, d_owner};
              state_nxt     = S_RES;
            end else begin
              adv = 1'b1;
            end
          end
          CMD_DELETE: begin
            if (!d_free && flags.owner_match) begin
              ram_we    = 1'b1;
              ram_wdata = {1'b1, d_owner, d_last};
            end
            if (at_end) begin
              state_nxt = S_IDLE;
            end else begin
              adv = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (d_free && flags.short_fit) begin
              if (check_r) begin
                ovf_nxt   = 1'b1;
                state_nxt = S_IDLE;
              end else begin
                si_nxt         = idx_r;
                j_nxt          = top_idx;
                split_last_nxt = split_last;
                old_last_nxt   = d_last;
                state_nxt      = (top_idx == idx_r) ? S_SP_A : S_SH_RD;
              end
            end else if ((d_free && flags.rem_done) || at_end) begin
              if (!check_r && d_free) begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, file_r, d_last};
              end
              if (check_r) begin
                idx_nxt   = '0;
                first_nxt = '0;
                rem_nxt   = count_r;
                check_nxt = 1'b0;
                state_nxt = S_RD;
              end else begin
                state_nxt = S_IDLE;
              end
            end else begin
              if (d_free) begin
                rem_nxt = rem_after;
                if (!check_r) begin
                  ram_we    = 1'b1;
                  ram_wdata = {1'b0, file_r, d_last};
                end
              end
              adv = 1'b1;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
        if (adv) begin
          idx_nxt   = idx_r + IW'(1);
          first_nxt = d_last + SECTOR_BITS'(1);
          state_nxt = S_RD;
        end
      end
      S_SH_RD: begin
        ram_re    = 1'b1;
        ram_raddr = j_r;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j_r + IW'(1);
        ram_wdata = ram_rdata;
        if (j_r == si_r + IW'(1)) begin
          state_nxt = S_SP_A;
        end else begin
          j_nxt     = j_r - IW'(1);
          state_nxt = S_SH_RD;
        end
      end
      S_SP_A: begin
        ram_we    = 1'b1;
        ram_waddr = si_r;
        ram_wdata = {1'b0, file_r, split_last_r};
        state_nxt = S_SP_B;
      end
      S_SP_B: begin
        ram_we    = 1'b1;
        ram_waddr = si_r + IW'(1);
        ram_wdata = {1'b1, {FILE_BITS{1'b0}}, old_last_r};
        total_nxt = total_r + TW'(1);
        state_nxt = S_IDLE;
      end
      S_RES: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_owner_nxt = res_owner_r;
          out_ovf_nxt   = ovf_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      total_r     <= TW'(1);
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    file_r       <= file_nxt;
    count_r      <= count_nxt;
    addr_r       <= addr_nxt;
    idx_r        <= idx_nxt;
    first_r      <= first_nxt;
    rem_r        <= rem_nxt;
    check_r      <= check_nxt;
    si_r         <= si_nxt;
    j_r          <= j_nxt;
    split_last_r <= split_last_nxt;
    old_last_r   <= old_last_nxt;
    res_owner_r  <= res_owner_nxt;
    out_owner_r  <= out_owner_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign in_ready           = state_r == S_IDLE;
  assign out_valid          = out_valid_r;
  assign out_owner_file     = out_owner_r;
  assign out_table_overflow = out_ovf_r;

endmodule

`default_nettype wire

// ===== rtl/core/esa_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; holds the extent table.
`default_nettype none

module esa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/esa_alu.sv =====
// Shared arithmetic unit: extent size, remaining count, split point and compares.
// Depends on esa_pkg for the flag struct.
`default_nettype none

module esa_alu #(
  parameter int SECTOR_BITS = 30,
  parameter int FILE_BITS   = 16
) (
  input  wire logic [SECTOR_BITS:0]   rem,
  input  wire logic [SECTOR_BITS-1:0] first,
  input  wire logic [SECTOR_BITS-1:0] last,
  input  wire logic [SECTOR_BITS-1:0] addr,
  input  wire logic [FILE_BITS-1:0]   file,
  input  wire logic [FILE_BITS-1:0]   owner,
  output logic      [SECTOR_BITS:0]   rem_after,
  output logic      [SECTOR_BITS-1:0] split_last,
  output esa_pkg::alu_flags_t         flags
);

  import esa_pkg::*;

  logic [SECTOR_BITS:0] size;

  assign size              = {1'b0, last} - {1'b0, first} + {{SECTOR_BITS{1'b0}}, 1'b1};
  assign rem_after         = rem - size;
  assign split_last        = first + rem[SECTOR_BITS-1:0] - {{(SECTOR_BITS-1){1'b0}}, 1'b1};
  assign flags.short_fit   = rem < size;
  assign flags.rem_done    = rem == size;
  assign flags.addr_hit    = addr <= last;
  assign flags.owner_match = owner == file;

endmodule

`default_nettype wire

// ===== rtl/core/esa_checker.sv =====
// Port-level checker for the extent sector allocator, bound to the top level.
// Depends on esa_pkg and extent_sector_allocator_defines.svh.
`default_nettype none

`include "extent_sector_allocator_defines.svh"

module esa_checker #(
  parameter int FILE_BITS = 16
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_valid,
  input wire logic                 in_ready,
  input wire esa_pkg::cmd_t        in_command,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [FILE_BITS:0]   out_owner_file,
  input wire logic                 out_table_overflow
);

  import esa_pkg::*;

  // A stalled result item keeps its contents.
  `ESA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_owner_file) && $stable(out_table_overflow))
  // A read walks the table, so the block is busy in the following cycle.
  `ESA_ASSERT_NEXT(a_read_busy, in_valid && in_ready && in_command == CMD_READ, !in_ready)
  // A free sector is reported as all ones, never as a partly negative owner.
  `ESA_ASSERT_IMPLY(a_free_code, out_valid && out_owner_file[FILE_BITS], &out_owner_file)
  // A new result item only appears after a busy cycle.
  `ESA_ASSERT_IMPLY(a_result_after_busy, $rose(out_valid), !$past(in_ready))

endmodule

bind extent_sector_allocator esa_checker #(
  .FILE_BITS (FILE_BITS)
) u_esa_checker (.*);

`default_nettype wire
